### hw/rtl/pid_controller_clamped_defines.svh
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Check a property on every rising edge while out of reset.
`define PIDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pidc: property violated");

// Check a property on every rising edge, reset included.
`define PIDC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pidc: property violated");

`endif

### hw/rtl/pidc_pkg.sv
package pidc_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_WIDTH = 16;
    localparam int ACC_WIDTH  = 32;

    localparam int ERR_WIDTH   = DATA_WIDTH + 1;
    localparam int DERR_WIDTH  = DATA_WIDTH + 2;
    localparam int PROD_WIDTH  = GAIN_WIDTH + ERR_WIDTH;
    localparam int PRODD_WIDTH = GAIN_WIDTH + DERR_WIDTH;
    localparam int CAND_WIDTH  = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
    localparam int SUM_WIDTH   = ((ACC_WIDTH > PRODD_WIDTH) ? ACC_WIDTH : PRODD_WIDTH) + 2;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic signed [GAIN_WIDTH-1:0]  gain_t;
    typedef logic signed [ACC_WIDTH-1:0]   acc_t;
    typedef logic signed [ERR_WIDTH-1:0]   err_t;
    typedef logic signed [DERR_WIDTH-1:0]  derr_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [PRODD_WIDTH-1:0] prodd_t;
    typedef logic signed [CAND_WIDTH-1:0]  cand_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_P  = 3'd0,
        CFG_GAIN_I  = 3'd1,
        CFG_GAIN_D  = 3'd2,
        CFG_OUT_MIN = 3'd3,
        CFG_OUT_MAX = 3'd4
    } cfg_index_t;

    localparam data_t OUT_MIN_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t OUT_MAX_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam acc_t  ACC_MIN       = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam acc_t  ACC_MAX       = {1'b0, {(ACC_WIDTH-1){1'b1}}};

    // Result of one controller pass, handed from the datapath to the top level.
    typedef struct packed {
        data_t drive;
        logic  clamped;
        acc_t  integ;
        err_t  err;
    } pidc_calc_t;

endpackage

### hw/rtl/pid_controller_clamped.sv
// PID controller with clamped output and conditional-integration anti-windup.
// Input channel (s_valid/s_ready): one sample per transfer, carrying the
// setpoint and the measured value as signed integers.
// Result channel (m_valid/m_ready): one transfer per sample with the clamped
// drive value and a flag that is set when a limit acted (integrator frozen).
// Configuration channel (cfg_valid/cfg_ready): index 0..4 selects gain_p,
// gain_i, gain_d, out_min, out_max; other indexes are ignored. Always ready;
// write it only while no sample is in flight.
// Path: a sample is captured in the input register, computed in one pass
// and loaded into the result register, which drives the result channel.
// Throughput: one sample per cycle while m_ready is high; the integrator and
// previous-error registers close a loop through the multiply/add/clamp pass.
// Reset (aresetn low, synchronous): gains clear to zero, limits go to the
// full signed range, integrator and previous error clear, both stages empty.
// Stall: when m_ready is low the result is held; the input register still
// takes one more sample, after which s_ready drops until the result moves.
module pid_controller_clamped (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pidc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pidc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // sample input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  pidc_pkg::data_t                         s_setpoint,
    input  pidc_pkg::data_t                         s_measured,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output pidc_pkg::data_t                         m_drive,
    output logic                                    m_clamped
);
    import pidc_pkg::*;

    // configuration registers
    gain_t gain_p_reg;
    gain_t gain_i_reg;
    gain_t gain_d_reg;
    data_t out_min_reg;
    data_t out_max_reg;

    // controller state
    acc_t  integ_reg;
    err_t  last_err_reg;

    // input stage
    logic  in_valid_reg;
    data_t setpoint_reg;
    data_t measured_reg;

    // result stage
    logic  out_valid_reg;
    data_t drive_reg;
    logic  clamped_reg;

    pidc_calc_t calc;
    logic       advance;
    logic       cfg_write;

    // Move a sample from the input stage to the result stage whenever the
    // result stage is empty or its contents leave in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            out_min_reg <= OUT_MIN_RESET;
            out_max_reg <= OUT_MAX_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:  gain_p_reg  <= gain_t'(cfg_data[GAIN_WIDTH-1:0]);
                CFG_GAIN_I:  gain_i_reg  <= gain_t'(cfg_data[GAIN_WIDTH-1:0]);
                CFG_GAIN_D:  gain_d_reg  <= gain_t'(cfg_data[GAIN_WIDTH-1:0]);
                CFG_OUT_MIN: out_min_reg <= data_t'(cfg_data[DATA_WIDTH-1:0]);
                CFG_OUT_MAX: out_max_reg <= data_t'(cfg_data[DATA_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    // Input register: capture a sample on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            setpoint_reg <= s_setpoint;
            measured_reg <= s_measured;
        end
    end

    // One pass: error, three products, saturated integrator, sum and clamp.
    pidc_datapath u_datapath (
        .setpoint (setpoint_reg),
        .measured (measured_reg),
        .gain_p   (gain_p_reg),
        .gain_i   (gain_i_reg),
        .gain_d   (gain_d_reg),
        .out_min  (out_min_reg),
        .out_max  (out_max_reg),
        .integ    (integ_reg),
        .last_err (last_err_reg),
        .calc     (calc)
    );

    // Controller state advances with each sample; the integrator holds its
    // value when the clamp acted (the datapath returns the old value then).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else if (advance) begin
            integ_reg    <= calc.integ;
            last_err_reg <= calc.err;
        end
    end

    // Result register: load on advance, drop after the output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg   <= calc.drive;
            clamped_reg <= calc.clamped;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = drive_reg;
    assign m_clamped = clamped_reg;

endmodule

### hw/rtl/pidc_datapath.sv
module pidc_datapath (
    input  pidc_pkg::data_t      setpoint,
    input  pidc_pkg::data_t      measured,
    input  pidc_pkg::gain_t      gain_p,
    input  pidc_pkg::gain_t      gain_i,
    input  pidc_pkg::gain_t      gain_d,
    input  pidc_pkg::data_t      out_min,
    input  pidc_pkg::data_t      out_max,
    input  pidc_pkg::acc_t       integ,
    input  pidc_pkg::err_t       last_err,
    output pidc_pkg::pidc_calc_t calc
);
    import pidc_pkg::*;

    err_t   err;
    derr_t  derr;
    prod_t  prod_p;
    prod_t  prod_i;
    prodd_t prod_d;
    prod_t  term_p;
    prod_t  term_i;
    prodd_t term_d;
    cand_t  cand_full;
    acc_t   cand_sat;
    sum_t   sum;
    sum_t   lim_lo;
    sum_t   lim_hi;

    assign err    = err_t'(setpoint) - err_t'(measured);
    assign derr   = derr_t'(err) - derr_t'(last_err);

    assign prod_p = prod_t'(gain_p) * prod_t'(err);
    assign prod_i = prod_t'(gain_i) * prod_t'(err);
    assign prod_d = prodd_t'(gain_d) * prodd_t'(derr);

    // floor rounding: arithmetic shift
    assign term_p = prod_p >>> FRAC_BITS;
    assign term_i = prod_i >>> FRAC_BITS;
    assign term_d = prod_d >>> FRAC_BITS;

    assign cand_full = cand_t'(integ) + cand_t'(term_i);

    always_comb begin
        priority if (cand_full > cand_t'(ACC_MAX)) begin
            cand_sat = ACC_MAX;
        end else if (cand_full < cand_t'(ACC_MIN)) begin
            cand_sat = ACC_MIN;
        end else begin
            cand_sat = acc_t'(cand_full);
        end
    end

    assign sum    = sum_t'(term_p) + sum_t'(cand_sat) + sum_t'(term_d);
    assign lim_lo = sum_t'(out_min);
    assign lim_hi = sum_t'(out_max);

    always_comb begin
        calc.err = err;
        // lower limit wins when the limits are crossed
        priority if (sum < lim_lo) begin
            calc.drive   = out_min;
            calc.clamped = 1'b1;
            calc.integ   = integ;
        end else if (sum > lim_hi) begin
            calc.drive   = out_max;
            calc.clamped = 1'b1;
            calc.integ   = integ;
        end else begin
            calc.drive   = data_t'(sum);
            calc.clamped = 1'b0;
            calc.integ   = cand_sat;
        end
    end

endmodule

### hw/rtl/pidc_checker.sv
`include "pid_controller_clamped_defines.svh"

module pidc_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input pidc_pkg::data_t m_drive,
    input logic            m_clamped
);
    import pidc_pkg::*;

    // A held result keeps its payload until the transfer.
    `PIDC_ASSERT(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_clamped))

    // An empty result stage never back-pressures the input.
    `PIDC_ASSERT(a_empty_accepts, aclk, aresetn, !m_valid |-> s_ready)

    // Reset empties the result stage.
    `PIDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);
